// ===== design/gwt_pkg.sv =====
package gwt_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FDIV,
    ST_MUL_A,
    ST_MUL_B,
    ST_COMB,
    ST_TDIV,
    ST_FEND,
    ST_IEND,
    ST_OUT
  } gwt_state_e;

  localparam int unsigned QW   = 37;  // truncated quotient / torque term width
  localparam int unsigned DMAG = 36;  // divider magnitude width
  localparam int unsigned SUMW = 40;  // running sum width

  localparam logic       REQ_FWD  = 1'b0;
  localparam logic       REQ_INV  = 1'b1;
  localparam logic       KIND_OBJ = 1'b0;
  localparam logic       KIND_CON = 1'b1;

  localparam logic [2:0] REG_COUNT = 3'd0;
  localparam logic [2:0] REG_POS0  = 3'd1;
  localparam logic [2:0] REG_POS1  = 3'd2;
  localparam logic [2:0] REG_POS2  = 3'd3;
  localparam logic [2:0] REG_POS3  = 3'd4;

  typedef struct packed {
    logic                  start;
    logic signed [QW-1:0]  dividend;
    logic [2:0]            divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [QW-1:0]  quotient;
  } div_rsp_t;

  function automatic logic signed [SUMW-1:0] sat40(input logic signed [SUMW:0] v);
    logic signed [SUMW-1:0] r;
    if (v[SUMW] != v[SUMW-1]) begin
      r = v[SUMW] ? {1'b1, {(SUMW-1){1'b0}}} : {1'b0, {(SUMW-1){1'b1}}};
    end else begin
      r = v[SUMW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUMW:0] v);
    logic signed [31:0] r;
    if ((&v[SUMW:31]) || !(|v[SUMW:31])) begin
      r = v[31:0];
    end else begin
      r = v[SUMW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== design/gwt_div.sv =====
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module gwt_div
  import gwt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic            busy_q;
  logic            done_q;
  logic [5:0]      cnt_q;
  logic [2:0]      rem_q;
  logic [2:0]      dvs_q;
  logic [DMAG-1:0] mag_q;
  logic            neg_q;

  logic signed [QW-1:0] abs_v;
  logic [3:0]           r2;
  logic                 ge;
  logic [3:0]           r2_sub;
  logic [QW-1:0]        qmag;

  assign abs_v  = req_i.dividend[QW-1] ? -req_i.dividend : req_i.dividend;
  assign r2     = {rem_q, mag_q[DMAG-1]};
  assign ge     = r2 >= {1'b0, dvs_q};
  assign r2_sub = r2 - {1'b0, dvs_q};
  assign qmag   = {1'b0, mag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(DMAG);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      mag_q <= abs_v[DMAG-1:0];
      neg_q <= req_i.dividend[QW-1];
    end else if (busy_q) begin
      rem_q <= ge ? r2_sub[2:0] : r2[2:0];
      mag_q <= {mag_q[DMAG-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -$signed(qmag) : $signed(qmag);

endmodule

// ===== design/grasp_wrench_transform_unit.sv =====
// Grasp wrench transform.
// Input stream s_axis: one wrench per beat; tuser selects accumulate (contact
// wrench, forward) or distribute (object wrench, inverse). Output stream
// m_axis: one wrench per beat, tuser is the result kind, tlast marks the
// final result caused by an input beat. Config port: cfg_we_i writes
// cfg_data_i to register cfg_idx_i (count, then contact positions 0..3).
// Datapath: a single 16x32 multiplier forms the two cross products of each
// axis one after the other (MUL_A, MUL_B, then COMB), and a one-bit-per-cycle
// divider divides by the contact count (FDIV for forces, TDIV for torques).
//   forward beat: three axes of multiply and combine into the running sums,
//   then FEND; the output register is loaded when it closes the run and emits.
//   inverse beat: the three force shares are divided first, then for each
//   contact every axis is multiplied and divided; m contacts give m beats.
// The block takes one input beat at a time: s_axis_tready is high only when
// idle. A finished beat is held in the output register until taken; a
// stalled receiver simply holds the block in that state.
// Reset: count 1, positions 0, running sums cleared, no output pending.
module grasp_wrench_transform_unit
  import gwt_pkg::*;
#(
  parameter int unsigned MAX_CONTACTS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // contact_index[1:0], force_x/y/z, torque_x/y/z (32 each), zero pad
  input  logic [199:0] s_axis_tdata,
  // req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_contact[1:0], out_force_x/y/z, out_torque_x/y/z (32 each), zero pad
  output logic [199:0] m_axis_tdata,
  // result_kind
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [47:0]  cfg_data_i
);

  localparam logic [2:0] MaxCnt = 3'(MAX_CONTACTS);

  gwt_state_e state_q, state_d;

  // configuration
  logic [2:0]  cnt_q;
  logic [47:0] pos_q [4];
  logic [2:0]  m_eff;

  // latched item
  logic                type_q;
  logic [1:0]          idx_q;
  logic [2:0]          m_q;
  logic signed [31:0]  f_q [3];
  logic signed [31:0]  t_q [3];

  // sequencing
  logic [1:0] j_q, j_d;
  logic [1:0] c_q, c_d;
  logic       div_act_q;

  // datapath
  logic signed [SUMW-1:0] sum_q [6];
  logic signed [47:0]     prod_q, hold_q;
  logic signed [QW-1:0]   tq_q;
  logic signed [QW-1:0]   wf_q [3];
  logic signed [QW-1:0]   wt_q [3];

  // output register
  logic               kind_q, last_q;
  logic [1:0]         ocon_q;
  logic signed [31:0] ores_q [6];

  logic               acc;
  logic [47:0]        pos_sel;
  logic signed [15:0] r_v [3];
  logic signed [15:0] r_op;
  logic signed [31:0] f_op;
  logic signed [47:0] prod;
  logic signed [48:0] cr;
  logic signed [50:0] tsh, xv, xadj;
  logic signed [QW-1:0] tq;
  logic               div_state;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (cnt_q == 3'd0) begin
      m_eff = 3'd1;
    end else if (cnt_q > MaxCnt) begin
      m_eff = MaxCnt;
    end else begin
      m_eff = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd1;
      for (int k = 0; k < 4; k++) pos_q[k] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COUNT: cnt_q    <= cfg_data_i[2:0];
        REG_POS0:  pos_q[0] <= cfg_data_i;
        REG_POS1:  pos_q[1] <= cfg_data_i;
        REG_POS2:  pos_q[2] <= cfg_data_i;
        REG_POS3:  pos_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared multiplier: per axis, A then B product of the cross term
  assign pos_sel = pos_q[c_q];
  for (genvar k = 0; k < 3; k++) begin : g_r
    assign r_v[k] = pos_sel[16*k +: 16];
  end

  always_comb begin
    case (j_q)
      2'd0: begin
        r_op = (state_q == ST_MUL_B) ? r_v[2] : r_v[1];
        f_op = (state_q == ST_MUL_B) ? f_q[1] : f_q[2];
      end
      2'd1: begin
        r_op = (state_q == ST_MUL_B) ? r_v[0] : r_v[2];
        f_op = (state_q == ST_MUL_B) ? f_q[2] : f_q[0];
      end
      default: begin
        r_op = (state_q == ST_MUL_B) ? r_v[1] : r_v[0];
        f_op = (state_q == ST_MUL_B) ? f_q[0] : f_q[1];
      end
    endcase
  end

  assign prod = r_op * f_op;

  // tau scaled to Q.30, cross term added or taken off, back to Q.16 (toward zero)
  assign cr   = 49'(hold_q) - 49'(prod_q);
  assign tsh  = 51'(t_q[j_q]) <<< 14;
  assign xv   = (type_q == REQ_FWD) ? tsh - 51'(cr) : tsh + 51'(cr);
  assign xadj = xv[50] ? xv + 51'sd16383 : xv;
  assign tq   = xadj[50:14];

  assign div_state        = (state_q == ST_FDIV) || (state_q == ST_TDIV);
  assign div_req.start    = div_state && !div_act_q;
  assign div_req.dividend = (state_q == ST_FDIV) ? QW'(f_q[j_q]) : tq_q;
  assign div_req.divisor  = m_q;

  gwt_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    c_d     = c_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          j_d = 2'd0;
          if (s_axis_tuser == REQ_INV) begin
            state_d = ST_FDIV;
          end else if ({1'b0, s_axis_tdata[1:0]} < m_eff) begin
            c_d     = s_axis_tdata[1:0];
            state_d = ST_MUL_A;
          end
        end
      end
      ST_FDIV: begin
        if (div_rsp.done) begin
          if (j_q == 2'd2) begin
            j_d     = 2'd0;
            c_d     = 2'd0;
            state_d = ST_MUL_A;
          end else begin
            j_d = j_q + 2'd1;
          end
        end
      end
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_COMB;
      ST_COMB: begin
        if (type_q == REQ_INV) begin
          state_d = ST_TDIV;
        end else if (j_q == 2'd2) begin
          state_d = ST_FEND;
        end else begin
          j_d     = j_q + 2'd1;
          state_d = ST_MUL_A;
        end
      end
      ST_TDIV: begin
        if (div_rsp.done) begin
          if (j_q == 2'd2) begin
            state_d = ST_IEND;
          end else begin
            j_d     = j_q + 2'd1;
            state_d = ST_MUL_A;
          end
        end
      end
      ST_FEND: state_d = (idx_q == 2'(m_q - 3'd1)) ? ST_OUT : ST_IDLE;
      ST_IEND: state_d = ST_OUT;
      ST_OUT: begin
        if (m_axis_tready) begin
          if (type_q == REQ_FWD || last_q) begin
            state_d = ST_IDLE;
          end else begin
            c_d     = c_q + 2'd1;
            j_d     = 2'd0;
            state_d = ST_MUL_A;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      j_q       <= '0;
      c_q       <= '0;
      div_act_q <= 1'b0;
      for (int k = 0; k < 6; k++) sum_q[k] <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      c_q     <= c_d;
      if (div_req.start) begin
        div_act_q <= 1'b1;
      end else if (div_rsp.done) begin
        div_act_q <= 1'b0;
      end
      if (state_q == ST_COMB && type_q == REQ_FWD) begin
        sum_q[j_q]      <= sat40(41'(sum_q[j_q]) + 41'(f_q[j_q]));
        sum_q[3 + j_q]  <= sat40(41'(sum_q[3 + j_q]) + 41'(tq));
      end
      if (state_q == ST_FEND && idx_q == 2'(m_q - 3'd1)) begin
        for (int k = 0; k < 6; k++) sum_q[k] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      type_q <= s_axis_tuser;
      idx_q  <= s_axis_tdata[1:0];
      m_q    <= m_eff;
      for (int k = 0; k < 3; k++) begin
        f_q[k] <= s_axis_tdata[2 + 32*k +: 32];
        t_q[k] <= s_axis_tdata[98 + 32*k +: 32];
      end
    end
    if (state_q == ST_MUL_A || state_q == ST_MUL_B) prod_q <= prod;
    if (state_q == ST_MUL_B) hold_q <= prod_q;
    if (state_q == ST_COMB) tq_q <= tq;
    if (state_q == ST_FDIV && div_rsp.done) wf_q[j_q] <= div_rsp.quotient;
    if (state_q == ST_TDIV && div_rsp.done) wt_q[j_q] <= div_rsp.quotient;
    if (state_q == ST_FEND) begin
      kind_q <= KIND_OBJ;
      ocon_q <= 2'd0;
      last_q <= 1'b1;
      for (int k = 0; k < 6; k++) ores_q[k] <= sat32(41'(sum_q[k]));
    end
    if (state_q == ST_IEND) begin
      kind_q <= KIND_CON;
      ocon_q <= c_q;
      last_q <= (c_q == 2'(m_q - 3'd1));
      for (int k = 0; k < 3; k++) begin
        ores_q[k]     <= sat32(41'(wf_q[k]));
        ores_q[3 + k] <= sat32(41'(wt_q[k]));
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {6'b0, ores_q[5], ores_q[4], ores_q[3],
                          ores_q[2], ores_q[1], ores_q[0], ocon_q};

endmodule

// ===== design/gwt_checker.sv =====
module gwt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [199:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast
);

  // one item at a time: never taking input while a result is offered
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // a held beat stays unchanged
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled beat changed");

  // an object wrench is always the only beat of its run
  a_obj_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("object wrench without tlast");

  // object wrench carries contact zero
  a_obj_con: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[1:0] == 2'd0)
    else $error("object wrench with contact index");

endmodule

bind grasp_wrench_transform_unit gwt_checker u_gwt_checker (.*);
